// ----- sv/token_ring_link_node_top_macros.svh -----
// Assertion macros shared by the token ring link node RTL.
`ifndef TOKEN_RING_LINK_NODE_TOP_MACROS_SVH
`define TOKEN_RING_LINK_NODE_TOP_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define TRLN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define TRLN_ASSERT_NEVER(lbl, expr, msg) \
  `TRLN_ASSERT(lbl, !(expr), msg)

`endif

// ----- sv/trln_pkg.sv -----
// Types, codes and helper functions shared by the token ring link node.
package trln_pkg;

  localparam int unsigned LEN_W = 4;

  localparam logic [1:0] MODE_RX    = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_SEND  = 2'd2;
  localparam logic [1:0] MODE_START = 2'd3;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_DLV  = 2'd1;
  localparam logic [1:0] KIND_BUSY = 2'd2;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_NODE_ID    = 2'd1;
  localparam logic [1:0] REG_TO_BASE    = 2'd2;
  localparam logic [1:0] REG_TO_RANGE   = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] LFSR_SEED     = 16'hACE1;
  localparam logic [16:0] TICK_MAX      = 17'h1FFFF;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DSTART = 5'b00010,
    S_DEL    = 5'b00100,
    S_TX     = 5'b01000,
    S_BUSY   = 5'b10000
  } state_e;

  typedef struct packed {
    logic tick;
    logic draw;
  } timer_ctl_t;

  // True when the successor of the sender, modulo the node count, is this node.
  // A node count of zero counts as one.
  function automatic logic token_hit(input logic [1:0] sender, input logic [2:0] cnt,
                                     input logic [1:0] id);
    logic [2:0] s1;
    logic [2:0] succ;
    begin
      s1 = {1'b0, sender} + 3'd1;
      case (cnt)
        3'd0, 3'd1: succ = 3'd0;
        3'd2:       succ = {2'b00, s1[0]};
        3'd3:       succ = (s1 >= 3'd3) ? (s1 - 3'd3) : s1;
        3'd4:       succ = {1'b0, s1[1:0]};
        default:    succ = s1;
      endcase
      token_hit = (succ == {1'b0, id});
    end
  endfunction

endpackage

// ----- sv/trln_timer.sv -----
// Receive timeout timer: jitter LFSR, tick counter and drawn timeout limit.
module trln_timer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  trln_pkg::timer_ctl_t ctl_i,
  input  logic [15:0]          base_i,
  input  logic [15:0]          range_i,
  output logic                 timeout_o
);
  import trln_pkg::*;

  `include "token_ring_link_node_top_macros.svh"

  logic [15:0] lfsr_q, lfsr_d;
  logic [16:0] tick_q, tick_inc;
  logic [16:0] limit_q, limit_d;
  logic [31:0] jitter_prod;
  logic        fb;

  assign fb          = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
  assign lfsr_d      = {fb, lfsr_q[15:1]};
  assign jitter_prod = lfsr_d * range_i;
  assign limit_d     = {1'b0, base_i} + {1'b0, jitter_prod[31:16]};

  // The tick counter saturates and the compare uses the incremented count.
  assign tick_inc  = (tick_q == TICK_MAX) ? tick_q : (tick_q + 17'd1);
  assign timeout_o = (tick_inc >= limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q  <= LFSR_SEED;
      tick_q  <= '0;
      limit_q <= '0;
    end else if (ctl_i.draw) begin
      lfsr_q  <= lfsr_d;
      tick_q  <= '0;
      limit_q <= limit_d;
    end else if (ctl_i.tick) begin
      tick_q  <= tick_inc;
    end
  end

  `TRLN_ASSERT(a_draw_clears_tick, ctl_i.draw |=> tick_q == 17'd0, "tick count not cleared by draw")
  `TRLN_ASSERT(a_tick_monotonic, !ctl_i.draw |=> tick_q >= $past(tick_q), "tick count went back")
  `TRLN_ASSERT_NEVER(a_lfsr_nonzero, lfsr_q == 16'd0, "jitter LFSR locked at zero")

endmodule

// ----- sv/token_ring_link_node_top.sv -----
// Token ring link node: frame receiver, payload memory, transmit sequencer, result register.
// A transmit or busy beat passes the sequencer state register and then the result register;
// delivered payload also passes the S_DSTART read state and the registered read port.
// A new item is taken only once the sequencer is back in idle after its last result beat,
// and a delivered frame also spends a payload memory read turnaround in S_DSTART.
// Reset: asynchronous and active low; control registers take their defaults, no clearing pass.
module token_ring_link_node_top #(
  parameter int unsigned PAYLOAD_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input item channel.
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] rx_byte_i,
  input  logic [1:0] send_dest_i,
  input  logic [1:0] send_count_i,
  input  logic [7:0] send_first_i,
  input  logic [7:0] send_second_i,
  input  logic [7:0] send_third_i,
  // Result channel.
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_sender_o,
  output logic       out_last_o
);
  import trln_pkg::*;

  `include "token_ring_link_node_top_macros.svh"

  localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);

  // Configuration registers. The port never stalls; user must have writes land while node is idle, unchecked.
  logic [2:0]  node_count_q;
  logic [1:0]  node_id_q;
  logic [15:0] to_base_q;
  logic [15:0] to_range_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 3'd1;
      node_id_q    <= 2'd0;
      to_base_q    <= TIMEOUT_RESET;
      to_range_q   <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NODE_COUNT: node_count_q <= cfg_data_i[2:0];
        REG_NODE_ID:    node_id_q    <= cfg_data_i[1:0];
        REG_TO_BASE:    to_base_q    <= cfg_data_i;
        REG_TO_RANGE:   to_range_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame receive state.
  logic             phase_q, phase_d;
  logic [1:0]       sender_q, sender_d;
  logic [1:0]       recv_q, recv_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] pc_q, pc_d, pc_inc;

  // Send queue: one frame of one to three bytes.
  logic       tx_pending_q;
  logic [1:0] tx_dest_q;
  logic [1:0] tx_count_q;
  logic [7:0] tx_data_q [3];

  // Sequencer state.
  state_e           state_q, state_d;
  logic             do_tx_q;
  logic [LEN_W-1:0] del_len_q;
  logic [LEN_W-1:0] del_idx_q;
  logic [7:0]       tx_hdr_q;
  logic [1:0]       tx_len_q;
  logic [1:0]       tx_idx_q;

  // Payload memory: written by the receiver, read back through a registered read port for delivery.
  logic [7:0]    pay_mem [PAYLOAD_DEPTH];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  // Result register.
  logic       out_valid_q;
  logic [1:0] out_kind_q;
  logic [7:0] out_byte_q;
  logic [1:0] out_sender_q;
  logic       out_last_q;

  logic       in_acc, timeout, can_push, push;
  logic       busy, deliver, do_tx, draw, load_send, del_last;
  logic [1:0] p_kind;
  logic [7:0] p_byte;
  logic [1:0] p_sender;
  logic       p_last;
  timer_ctl_t tctl;

  // New items enter only while the sequencer is idle; the result register may still hold
  // the previous item's last beat.
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign pc_inc     = pc_q + 4'd1;

  trln_timer u_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (tctl),
    .base_i    (to_base_q),
    .range_i   (to_range_q),
    .timeout_o (timeout)
  );

  // Decode of an accepted item: frame bookkeeping, timer control and what to emit.
  always_comb begin
    phase_d   = phase_q;
    sender_d  = sender_q;
    recv_d    = recv_q;
    len_d     = len_q;
    pc_d      = pc_q;
    mem_we    = 1'b0;
    busy      = 1'b0;
    deliver   = 1'b0;
    do_tx     = 1'b0;
    draw      = 1'b0;
    load_send = 1'b0;
    tctl      = '0;
    if (in_acc) begin
      case (mode_i)
        MODE_RX: begin
          if (!phase_q) begin
            sender_d = rx_byte_i[7:6];
            recv_d   = rx_byte_i[5:4];
            len_d    = rx_byte_i[3:0];
            pc_d     = '0;
            if (rx_byte_i[3:0] == 4'd0) begin
              do_tx = token_hit(rx_byte_i[7:6], node_count_q, node_id_q);
            end else begin
              phase_d = 1'b1;
            end
            draw = 1'b1;
          end else begin
            mem_we = 1'b1;
            if (pc_inc == len_q) begin
              deliver = (recv_q == node_id_q);
              do_tx   = token_hit(sender_q, node_count_q, node_id_q);
              phase_d = 1'b0;
              pc_d    = '0;
              draw    = 1'b1;
            end else begin
              pc_d = pc_inc;
            end
          end
        end
        MODE_TICK: begin
          tctl.tick = 1'b1;
          if (timeout) begin
            do_tx   = 1'b1;
            phase_d = 1'b0;
            pc_d    = '0;
            draw    = 1'b1;
          end
        end
        MODE_SEND: begin
          if (tx_pending_q) begin
            busy = 1'b1;
          end else begin
            load_send = 1'b1;
          end
        end
        MODE_START: begin
          do_tx   = (node_id_q == 2'd0);
          phase_d = 1'b0;
          pc_d    = '0;
          draw    = 1'b1;
        end
        default: ;
      endcase
    end
    tctl.draw = draw;
  end

  assign can_push = !out_valid_q || out_ready_i;
  assign del_last = (del_idx_q == (del_len_q - 4'd1));

  // Output sequencer. Delivered bytes go first, then the transmitted frame; a refused send gives a single busy beat.
  always_comb begin
    state_d  = state_q;
    push     = 1'b0;
    p_kind   = KIND_TX;
    p_byte   = 8'd0;
    p_sender = 2'd0;
    p_last   = 1'b0;
    rd_addr  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (busy) begin
            state_d = S_BUSY;
          end else if (deliver) begin
            state_d = S_DSTART;
          end else if (do_tx) begin
            state_d = S_TX;
          end
        end
      end
      S_DSTART: begin
        // Read of the first payload byte is in flight.
        state_d = S_DEL;
      end
      S_DEL: begin
        p_kind   = KIND_DLV;
        p_byte   = rd_data_q;
        p_sender = sender_q;
        p_last   = del_last && !do_tx_q;
        push     = can_push;
        // Keep the read one entry ahead of the beat being shown.
        rd_addr  = push ? AW'(del_idx_q + 4'd1) : AW'(del_idx_q);
        if (push && del_last) begin
          state_d = do_tx_q ? S_TX : S_IDLE;
        end
      end
      S_TX: begin
        p_kind = KIND_TX;
        case (tx_idx_q)
          2'd0:    p_byte = tx_hdr_q;
          2'd1:    p_byte = tx_data_q[0];
          2'd2:    p_byte = tx_data_q[1];
          default: p_byte = tx_data_q[2];
        endcase
        p_last = (tx_idx_q == tx_len_q);
        push   = can_push;
        if (push && p_last) begin
          state_d = S_IDLE;
        end
      end
      S_BUSY: begin
        p_kind = KIND_BUSY;
        p_last = 1'b1;
        push   = can_push;
        if (push) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= 1'b0;
      sender_q     <= '0;
      recv_q       <= '0;
      len_q        <= '0;
      pc_q         <= '0;
      tx_pending_q <= 1'b0;
      tx_dest_q    <= '0;
      tx_count_q   <= '0;
      do_tx_q      <= 1'b0;
      del_len_q    <= '0;
      del_idx_q    <= '0;
      tx_len_q     <= '0;
      tx_idx_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      sender_q <= sender_d;
      recv_q   <= recv_d;
      len_q    <= len_d;
      pc_q     <= pc_d;

      if (load_send) begin
        tx_pending_q <= 1'b1;
        tx_dest_q    <= send_dest_i;
        tx_count_q   <= (send_count_i == 2'd0) ? 2'd1 : send_count_i;
      end

      if (in_acc) begin
        do_tx_q   <= do_tx;
        del_len_q <= len_d == '0 ? len_q : len_d;
        if (do_tx) begin
          // The queued frame goes out with this transmit; the queue empties now.
          tx_len_q     <= tx_pending_q ? tx_count_q : 2'd0;
          tx_pending_q <= 1'b0;
        end
      end

      if (state_q != S_DEL) begin
        del_idx_q <= '0;
      end else if (push) begin
        del_idx_q <= del_idx_q + 4'd1;
      end

      if (state_q != S_TX) begin
        tx_idx_q <= '0;
      end else if (push) begin
        tx_idx_q <= tx_idx_q + 2'd1;
      end

      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (load_send) begin
      tx_data_q[0] <= send_first_i;
      tx_data_q[1] <= send_second_i;
      tx_data_q[2] <= send_third_i;
    end
    if (in_acc && do_tx) begin
      tx_hdr_q <= tx_pending_q ? {node_id_q, tx_dest_q, 2'b00, tx_count_q}
                               : {node_id_q, 6'd0};
    end
    if (push) begin
      out_kind_q   <= p_kind;
      out_byte_q   <= p_byte;
      out_sender_q <= p_sender;
      out_last_q   <= p_last;
    end
  end

  // Payload memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pay_mem[AW'(pc_q)] <= rx_byte_i;
    end
    rd_data_q <= pay_mem[rd_addr];
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_byte_o   = out_byte_q;
  assign out_sender_o = out_sender_q;
  assign out_last_o   = out_last_q;

  `TRLN_ASSERT(a_busy_when_pending, in_acc && mode_i == MODE_SEND && tx_pending_q |=> state_q == S_BUSY, "send while pending not refused")
  `TRLN_ASSERT_NEVER(a_no_write_in_delivery, mem_we && (state_q == S_DSTART || state_q == S_DEL), "payload write during delivery read")
  `TRLN_ASSERT_NEVER(a_tx_clears_pending, state_q == S_TX && tx_pending_q, "send queue still pending while transmitting")

endmodule
